// ===== sv/psched_pkg.sv =====
// Shared types, widths and codes for the process slot scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package psched_pkg;

    // Default table depth.
    localparam int NUM_SLOTS_DEF = 16;

    // Field widths of the transfer payloads.
    localparam int FUNC_W   = 3;
    localparam int ID_W     = 4;
    localparam int PRIO_W   = 8;
    localparam int STAT_W   = 3;
    localparam int POLICY_W = 2;

    // Width of the shared compare/subtract unit (holds a sign-extended
    // priority or a slot count with room for the borrow).
    localparam int ALU_W = 10;

    // Configuration port widths.
    localparam int APB_DW = 32;
    localparam int APB_AW = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SELECT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PAUSE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RESUME  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_KILL    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_FINISH  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SETPRIO = 3'd6;

    // Slot status codes.
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd0;
    localparam logic [STAT_W-1:0] ST_READY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_PAUSED     = 3'd2;
    localparam logic [STAT_W-1:0] ST_TERMINATED = 3'd3;
    localparam logic [STAT_W-1:0] ST_KILLED     = 3'd4;

    // Grant policies.
    localparam logic [POLICY_W-1:0] POL_RR      = 2'd0;
    localparam logic [POLICY_W-1:0] POL_PRIO    = 2'd1;
    localparam logic [POLICY_W-1:0] POL_PRIO_RR = 2'd2;

    // One entry of the slot table.
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [PRIO_W-1:0] prio;
    } t_slot;

endpackage

`default_nettype wire

// ===== sv/psched_in_if.sv =====
// Request channel of the process slot scheduler: valid/ready plus the request payload.
// Depends on psched_pkg for the field widths.
`default_nettype none

interface psched_in_if;
    import psched_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [ID_W-1:0]          proc_id;
    logic signed [PRIO_W-1:0] prio_value;

    modport source (output valid, output func, output proc_id, output prio_value,
                    input ready);
    modport sink   (input valid, input func, input proc_id, input prio_value,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/psched_out_if.sv =====
// Response channel of the process slot scheduler: valid/ready plus the response payload.
// Depends on psched_pkg for the field widths.
`default_nettype none

interface psched_out_if;
    import psched_pkg::*;

    logic            valid;
    logic            ready;
    logic            ok;
    logic [ID_W-1:0] result_id;

    modport source (output valid, output ok, output result_id, input ready);
    modport sink   (input valid, input ok, input result_id, output ready);
endinterface

`default_nettype wire

// ===== sv/psched_alu.sv =====
// Shared compare/subtract unit used by the select passes and the index reduction of the scheduler sequencer.
// Depends on psched_pkg for the operand width.
`default_nettype none

module psched_alu (
    input  logic signed [psched_pkg::ALU_W-1:0] i_a,
    input  logic signed [psched_pkg::ALU_W-1:0] i_b,
    output logic                                o_lt,
    output logic                                o_eq,
    output logic        [psched_pkg::ALU_W-1:0] o_diff
);
    import psched_pkg::*;

    logic signed [ALU_W-1:0] diff;

    // Operands are sign-extended into a width with room for the difference, so its sign is the order.
    assign diff   = i_a - i_b;
    assign o_diff = diff;
    assign o_lt   = diff[ALU_W-1];
    assign o_eq   = (diff == '0);
endmodule

`default_nettype wire

// ===== sv/psched_table.sv =====
// Slot table memory: one write port and one read port with registered read data.
// Depends on psched_pkg for the entry type.
`default_nettype none

module psched_table #(
    parameter int NUM_SLOTS = psched_pkg::NUM_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_waddr,
    input  psched_pkg::t_slot            i_wdata,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_raddr,
    output psched_pkg::t_slot            o_rdata
);
    import psched_pkg::*;

    t_slot r_mem [NUM_SLOTS];
    t_slot r_rdata;

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== sv/process_slot_scheduler_core.sv =====
// Process slot scheduler core. One request at a time; ready is high only when idle.
// Create, an unused function code and select under an unused policy go from idle
// straight to S_FIN; pause, resume, kill, finish and set priority pass S_CHK first.
// Select walks the slot table through one memory read port, one entry per cycle, in
// up to three passes (best priority, candidate count, pick) plus one shared-unit
// subtract per step of the index reduction.
// Reset (synchronous, active low) empties the table at once through the fill count.
`default_nettype none

module process_slot_scheduler_core #(
    parameter int NUM_SLOTS = psched_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    psched_in_if.sink                     i_in,
    psched_out_if.source                  o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psched_pkg::APB_AW-1:0] paddr,
    input  logic [psched_pkg::APB_DW-1:0] pwdata,
    output logic [psched_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import psched_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_BEST = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_PICK = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]               r_state,   n_state;
    logic [POLICY_W-1:0]      r_policy;
    logic [CNT_W-1:0]         r_nfid,    n_nfid;
    logic [IDX_W-1:0]         r_rot,     n_rot;
    logic [ID_W-1:0]          r_id,      n_id;
    logic [FUNC_W-1:0]        r_func,    n_func;
    logic signed [PRIO_W-1:0] r_prio,    n_prio;
    logic signed [PRIO_W-1:0] r_best,    n_best;
    logic                     r_have,    n_have;
    logic [CNT_W-1:0]         r_n,       n_n;
    logic [IDX_W-1:0]         r_cpos,    n_cpos;
    logic [CNT_W-1:0]         r_cnt,     n_cnt;
    logic                     r_pend,    n_pend;
    logic [IDX_W-1:0]         r_rd_idx,  n_rd_idx;
    logic                     r_ok,      n_ok;
    logic [ID_W-1:0]          r_rid,     n_rid;
    logic                     r_out_vld, n_out_vld;
    logic                     r_out_ok,  n_out_ok;
    logic [ID_W-1:0]          r_out_rid, n_out_rid;

    // Table ports.
    logic             t_we;
    logic [IDX_W-1:0] t_waddr;
    t_slot            t_wdata;
    logic [IDX_W-1:0] t_raddr;
    t_slot            t_rdata;

    // Shared unit ports.
    logic signed [ALU_W-1:0] alu_a;
    logic signed [ALU_W-1:0] alu_b;
    logic                    alu_lt;
    logic                    alu_eq;
    logic [ALU_W-1:0]        alu_diff;

    // Scan helpers.
    logic              scan_issue;
    logic              scan_last;
    logic              rd_ready;
    logic              id_live;
    logic [STAT_W-1:0] chk_st;
    logic              cand;
    logic [IDX_W-1:0]  pick_k;
    logic [CNT_W-1:0]  k_inc;
    logic              cfg_wr;

    psched_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    psched_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_lt   (alu_lt),
        .o_eq   (alu_eq),
        .o_diff (alu_diff)
    );

    // Configuration port: the only register reads at word address zero; a write to any address updates it.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr == '0) ? APB_DW'(r_policy) : '0;

    // Handshake outputs.
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_vld;
    assign o_out.ok        = r_out_ok;
    assign o_out.result_id = r_out_rid;

    // Table read address: the target slot on a transfer, else the scan counter.
    assign t_raddr = (r_state == S_IDLE) ? IDX_W'(i_in.proc_id) : r_cnt[IDX_W-1:0];

    // Scan bookkeeping: an entry read last cycle is processed this cycle.
    assign scan_issue = (r_cnt != CNT_W'(NUM_SLOTS));
    assign scan_last  = r_pend & ~scan_issue;
    assign rd_ready   = r_pend & (CNT_W'(r_rd_idx) < r_nfid) & (t_rdata.status == ST_READY);

    // Slots at or above the fill count are empty.
    assign id_live = (CMP_W'(r_id) < CMP_W'(r_nfid));
    assign chk_st  = id_live ? t_rdata.status : ST_EMPTY;

    // The shared unit reduces the index in S_MOD and compares priorities elsewhere.
    always_comb begin
        if (r_state == S_MOD) begin
            alu_a = signed'(ALU_W'(r_rot));
            alu_b = signed'(ALU_W'(r_n));
        end else begin
            alu_a = ALU_W'(t_rdata.prio);
            alu_b = ALU_W'(r_best);
        end
    end

    // Candidate test and grant position for the pick pass.
    assign cand   = rd_ready & ((r_policy == POL_RR) | alu_eq);
    assign pick_k = (r_policy == POL_PRIO) ? '0 : r_rot;
    assign k_inc  = CNT_W'(pick_k) + CNT_W'(1);

    // Sequencer next-state logic.
    always_comb begin
        n_state   = r_state;
        n_nfid    = r_nfid;
        n_rot     = r_rot;
        n_id      = r_id;
        n_func    = r_func;
        n_prio    = r_prio;
        n_best    = r_best;
        n_have    = r_have;
        n_n       = r_n;
        n_cpos    = r_cpos;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_rd_idx  = r_rd_idx;
        n_ok      = r_ok;
        n_rid     = r_rid;
        n_out_vld = r_out_vld;
        n_out_ok  = r_out_ok;
        n_out_rid = r_out_rid;
        t_we      = 1'b0;
        t_waddr   = r_nfid[IDX_W-1:0];
        t_wdata   = '{status: ST_READY, prio: i_in.prio_value};

        // Output register empties on a transfer.
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        // Scan counter advances in every scan pass.
        if (r_state == S_BEST || r_state == S_CNT || r_state == S_PICK) begin
            n_pend = scan_issue;
            if (scan_issue) begin
                n_rd_idx = r_cnt[IDX_W-1:0];
                n_cnt    = r_cnt + CNT_W'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_id   = i_in.proc_id;
                    n_func = i_in.func;
                    n_prio = i_in.prio_value;
                    n_ok   = 1'b0;
                    n_rid  = '0;
                    n_cnt  = '0;
                    n_pend = 1'b0;
                    unique case (i_in.func)
                        FN_CREATE: begin
                            n_state = S_FIN;
                            if (r_nfid != CNT_W'(NUM_SLOTS)) begin
                                t_we   = 1'b1;
                                n_ok   = 1'b1;
                                n_rid  = ID_W'(r_nfid);
                                n_nfid = r_nfid + CNT_W'(1);
                            end
                        end
                        FN_SELECT: begin
                            n_have = 1'b0;
                            n_n    = '0;
                            if (r_policy == POL_RR || r_policy == POL_PRIO ||
                                    r_policy == POL_PRIO_RR) begin
                                n_state = S_BEST;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        FN_PAUSE, FN_RESUME, FN_KILL, FN_FINISH, FN_SETPRIO: begin
                            n_state = S_CHK;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // Status check and update of one targeted slot.
            S_CHK: begin
                n_state = S_FIN;
                t_waddr = IDX_W'(r_id);
                t_wdata = t_rdata;
                unique case (r_func)
                    FN_PAUSE: begin
                        if (chk_st == ST_READY) begin
                            t_wdata.status = ST_PAUSED;
                            t_we           = 1'b1;
                        end
                    end
                    FN_RESUME: begin
                        if (chk_st == ST_PAUSED) begin
                            t_wdata.status = ST_READY;
                            t_we           = 1'b1;
                        end
                    end
                    FN_KILL, FN_FINISH: begin
                        if (chk_st == ST_READY || chk_st == ST_PAUSED) begin
                            t_wdata.status = (r_func == FN_KILL) ? ST_KILLED : ST_TERMINATED;
                            t_we           = 1'b1;
                        end
                    end
                    FN_SETPRIO: begin
                        if (chk_st != ST_EMPTY) begin
                            t_wdata.prio = r_prio;
                            t_we         = 1'b1;
                        end
                    end
                    default: begin
                        t_we = 1'b0;
                    end
                endcase
                n_ok = t_we;
            end

            // First pass: best priority and the count of ready slots.
            S_BEST: begin
                if (rd_ready) begin
                    n_n = r_n + CNT_W'(1);
                    if (!r_have || alu_lt) begin
                        n_best = t_rdata.prio;
                        n_have = 1'b1;
                    end
                end
                if (scan_last) begin
                    n_cnt  = '0;
                    n_pend = 1'b0;
                    n_cpos = '0;
                    if (!n_have) begin
                        n_state = S_FIN;
                    end else if (r_policy == POL_PRIO) begin
                        n_state = S_PICK;
                    end else if (r_policy == POL_PRIO_RR) begin
                        n_n     = '0;
                        n_state = S_CNT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end

            // Second pass: count the ready slots that share the best priority.
            S_CNT: begin
                if (rd_ready && alu_eq) begin
                    n_n = r_n + CNT_W'(1);
                end
                if (scan_last) begin
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_state = S_MOD;
                end
            end

            // Reduce the rotate index below the candidate count, one subtract a step.
            S_MOD: begin
                if (!alu_lt) begin
                    n_rot = alu_diff[IDX_W-1:0];
                end else begin
                    n_state = S_PICK;
                end
            end

            // Last pass: grant the candidate at the reduced index, or the first candidate under the priority policy.
            S_PICK: begin
                if (cand) begin
                    if (r_cpos == pick_k) begin
                        n_ok    = 1'b1;
                        n_rid   = ID_W'(r_rd_idx);
                        n_state = S_FIN;
                        if (r_policy != POL_PRIO) begin
                            n_rot = (k_inc == r_n) ? '0 : k_inc[IDX_W-1:0];
                        end
                    end else begin
                        n_cpos = r_cpos + IDX_W'(1);
                    end
                end
                if (scan_last && n_state == S_PICK) begin
                    n_state = S_FIN;
                end
            end

            // Hand the response to the output register once it is free.
            S_FIN: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_ok  = r_ok;
                    n_out_rid = r_ok ? r_rid : '0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_policy  <= POL_RR;
            r_nfid    <= '0;
            r_rot     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_nfid    <= n_nfid;
            r_rot     <= n_rot;
            r_out_vld <= n_out_vld;
            if (cfg_wr) begin
                r_policy <= pwdata[POLICY_W-1:0];
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_func    <= n_func;
        r_prio    <= n_prio;
        r_best    <= n_best;
        r_have    <= n_have;
        r_n       <= n_n;
        r_cpos    <= n_cpos;
        r_cnt     <= n_cnt;
        r_pend    <= n_pend;
        r_rd_idx  <= n_rd_idx;
        r_ok      <= n_ok;
        r_rid     <= n_rid;
        r_out_ok  <= n_out_ok;
        r_out_rid <= n_out_rid;
    end
endmodule

`default_nettype wire

// ===== sim/process_slot_scheduler_core_tb.sv =====
// Self-checking testbench for process_slot_scheduler_core: directed and random requests
// are compared against a slot-table scoreboard. Depends on psched_pkg and the two
// channel interfaces psched_in_if and psched_out_if.

module process_slot_scheduler_core_tb;
    import psched_pkg::*;

    localparam int SLOTS          = NUM_SLOTS_DEF;
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4 * SLOTS + 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_STEP = 47;

    localparam logic [FUNC_W-1:0]     FN_UNUSED  = 3'd7;
    localparam logic [POLICY_W-1:0]   POL_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0]     REG_POLICY = 2'd0;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -8'sd128;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 8'sd127;

    // Slot table scoreboard: mirrors the scheduler state and queues expected responses.
    class sched_scoreboard;
        typedef struct packed {
            logic            ok;
            logic [ID_W-1:0] rid;
        } t_resp;

        logic [STAT_W-1:0]        slot_status [SLOTS];
        logic signed [PRIO_W-1:0] slot_prio   [SLOTS];
        int unsigned              rotate_pos;
        int unsigned              next_id;
        logic [POLICY_W-1:0]      policy;
        t_resp                    expected_q [$];
        int                       error_count;

        function new();
            foreach (slot_status[i]) begin
                slot_status[i] = ST_EMPTY;
                slot_prio[i]   = '0;
            end
            rotate_pos  = 0;
            next_id     = 0;
            policy      = POL_RR;
            error_count = 0;
        endfunction

        function void set_policy(logic [POLICY_W-1:0] p);
            policy = p;
        endfunction

        // Grant decision for a select, including the rotating index update.
        function t_resp grant_select();
            t_resp                    r;
            logic signed [PRIO_W-1:0] best;
            bit                       have;
            int unsigned              cand [$];
            r    = '0;
            best = '0;
            have = 1'b0;
            if (policy > POL_PRIO_RR)
                return r;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_status[i] == ST_READY && (!have || slot_prio[i] < best)) begin
                    best = slot_prio[i];
                    have = 1'b1;
                end
            end
            if (!have)
                return r;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_status[i] == ST_READY && (policy == POL_RR || slot_prio[i] == best))
                    cand = {cand, i};
            end
            r.ok = 1'b1;
            if (policy == POL_PRIO) begin
                r.rid = ID_W'(cand[0]);
            end else begin
                rotate_pos = rotate_pos % cand.size();
                r.rid      = ID_W'(cand[rotate_pos]);
                rotate_pos = (rotate_pos + 1) % cand.size();
            end
            return r;
        endfunction

        // Applies one request to the mirrored table and returns its response.
        function t_resp predict_response(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                         logic signed [PRIO_W-1:0] pr);
            t_resp             r;
            logic [STAT_W-1:0] st;
            r  = '0;
            st = slot_status[id];
            case (fn)
                FN_CREATE: begin
                    if (next_id < SLOTS) begin
                        slot_status[next_id] = ST_READY;
                        slot_prio[next_id]   = pr;
                        r.ok                 = 1'b1;
                        r.rid                = ID_W'(next_id);
                        next_id++;
                    end
                end
                FN_SELECT: begin
                    r = grant_select();
                end
                FN_PAUSE: begin
                    if (st == ST_READY) begin
                        slot_status[id] = ST_PAUSED;
                        r.ok            = 1'b1;
                    end
                end
                FN_RESUME: begin
                    if (st == ST_PAUSED) begin
                        slot_status[id] = ST_READY;
                        r.ok            = 1'b1;
                    end
                end
                FN_KILL, FN_FINISH: begin
                    if (st == ST_READY || st == ST_PAUSED) begin
                        slot_status[id] = (fn == FN_KILL) ? ST_KILLED : ST_TERMINATED;
                        r.ok            = 1'b1;
                    end
                end
                FN_SETPRIO: begin
                    if (st != ST_EMPTY) begin
                        slot_prio[id] = pr;
                        r.ok          = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (!r.ok)
                r.rid = '0;
            return r;
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                   logic signed [PRIO_W-1:0] pr);
            expected_q = {expected_q, predict_response(fn, id, pr)};
        endfunction

        function void check_response(logic ok, logic [ID_W-1:0] rid);
            t_resp want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual ok=%0b result_id=%0d",
                         $time, ok, rid);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (ok !== want.ok) begin
                $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, ok);
                error_count++;
            end
            if (rid !== want.rid) begin
                $display("%0t: result_id mismatch, expected %0d, actual %0d",
                         $time, want.rid, rid);
                error_count++;
            end
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    psched_in_if  req_if ();
    psched_out_if rsp_if ();

    sched_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    bit              hold_request;
    int              quiet_cycles;

    process_slot_scheduler_core #(
        .NUM_SLOTS(SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Response side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left     = 0;
        rsp_if.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every response transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.ok, rsp_if.result_id);
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request and waits for its transfer; valid stays high afterwards.
    task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                                 input logic signed [PRIO_W-1:0] pr);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.func       = fn;
        req_if.proc_id    = id;
        req_if.prio_value = pr;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        sb.note_request(fn, id, pr);
        @(negedge i_clk);
    endtask

    // Stops offering requests and waits until every expected response has arrived.
    task automatic drain_responses();
        req_if.valid = 1'b0;
        while (sb.pending_count() != 0)
            @(negedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input bit wr, input logic [APB_AW-1:0] addr,
                                input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        if (wr && addr == REG_POLICY)
            sb.set_policy(data[POLICY_W-1:0]);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Changes the grant policy while idle and reads it back.
    task automatic set_policy_mode(input logic [POLICY_W-1:0] p);
        logic [APB_DW-1:0] rdata;
        drain_responses();
        apb_transfer(1'b1, REG_POLICY, APB_DW'(p), rdata);
        apb_transfer(1'b0, REG_POLICY, '0, rdata);
        if (rdata[POLICY_W-1:0] !== p) begin
            $display("%0t: policy_mode readback mismatch, expected %0d, actual %0d",
                     $time, p, rdata[POLICY_W-1:0]);
            sb.error_count++;
        end
    endtask

    // Random request, biased toward live slots and clustered priorities.
    task automatic issue_random_request();
        logic [FUNC_W-1:0]        fn;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] pr;
        int                       roll;
        roll = $urandom_range(99);
        if (roll < 8)       fn = FN_CREATE;
        else if (roll < 42) fn = FN_SELECT;
        else if (roll < 55) fn = FN_PAUSE;
        else if (roll < 68) fn = FN_RESUME;
        else if (roll < 70) fn = FN_KILL;
        else if (roll < 72) fn = FN_FINISH;
        else if (roll < 96) fn = FN_SETPRIO;
        else                fn = FN_UNUSED;
        if ($urandom_range(9) < 8 && sb.next_id > 0)
            id = ID_W'($urandom_range(sb.next_id - 1));
        else
            id = ID_W'($urandom_range(SLOTS - 1));
        roll = $urandom_range(9);
        if (roll < 5)      pr = PRIO_W'(int'($urandom_range(4)) - 2);
        else if (roll < 7) pr = $urandom_range(1) ? PRIO_MAX : PRIO_MIN;
        else               pr = PRIO_W'($urandom_range(255));
        issue_request(fn, id, pr);
    endtask

    // Stimulus sequence.
    initial begin
        logic [POLICY_W-1:0] phase_policy [3][3];
        int                  phase_send [3];
        int                  phase_recv [3];
        phase_policy = '{'{POL_RR, POL_PRIO, POL_PRIO_RR},
                         '{POL_PRIO_RR, POL_RR, POL_PRIO},
                         '{POL_PRIO, POL_PRIO_RR, POL_RR}};
        phase_send   = '{30, 65, 0};
        phase_recv   = '{65, 30, 0};
        sb                = new();
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_if.valid      = 1'b0;
        req_if.func       = '0;
        req_if.proc_id    = '0;
        req_if.prio_value = '0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        hold_request      = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, failing operations, extremes and every function.
        set_policy_mode(POL_RR);
        issue_request(FN_SELECT, 4'd0, 8'sd0);
        issue_request(FN_PAUSE, 4'd0, 8'sd0);
        issue_request(FN_SETPRIO, 4'd15, 8'sd0);
        issue_request(FN_UNUSED, 4'd15, -8'sd1);
        issue_request(FN_CREATE, 4'd0, PRIO_MIN);
        issue_request(FN_CREATE, 4'd15, PRIO_MAX);
        issue_request(FN_CREATE, 4'd0, 8'sd0);
        issue_request(FN_CREATE, 4'd0, PRIO_MIN);
        issue_request(FN_SELECT, 4'd0, 8'sd0);
        issue_request(FN_SELECT, 4'd0, 8'sd0);
        issue_request(FN_PAUSE, 4'd1, 8'sd0);
        issue_request(FN_PAUSE, 4'd1, 8'sd0);
        issue_request(FN_RESUME, 4'd1, 8'sd0);
        issue_request(FN_RESUME, 4'd1, 8'sd0);
        issue_request(FN_SETPRIO, 4'd2, PRIO_MAX);
        issue_request(FN_KILL, 4'd2, 8'sd0);
        issue_request(FN_KILL, 4'd2, 8'sd0);
        issue_request(FN_SETPRIO, 4'd2, -8'sd1);
        issue_request(FN_FINISH, 4'd1, 8'sd0);
        issue_request(FN_RESUME, 4'd1, 8'sd0);

        // Priority tie between slots 0 and 3, then the unused policy and the rotating priority policy.
        set_policy_mode(POL_PRIO);
        issue_request(FN_SELECT, 4'd0, 8'sd0);
        set_policy_mode(POL_UNUSED);
        issue_request(FN_SELECT, 4'd0, 8'sd0);
        set_policy_mode(POL_PRIO_RR);
        repeat (3) issue_request(FN_SELECT, 4'd0, 8'sd0);

        // Random phases with changing idle patterns and policies.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = phase_send[ph];
            recv_idle_pct = phase_recv[ph];
            for (int st = 0; st < 3; st++) begin
                set_policy_mode(phase_policy[ph][st]);
                if (ph == 0 && st == 1)
                    hold_request = 1'b1;
                repeat (ITEMS_PER_STEP) issue_random_request();
            end
        end

        // Fill the table, try one create past the end and select once.
        drain_responses();
        while (sb.next_id < SLOTS)
            issue_request(FN_CREATE, 4'd0, PRIO_W'($urandom_range(255)));
        issue_request(FN_CREATE, 4'd0, PRIO_MIN);
        issue_request(FN_SELECT, 4'd0, 8'sd0);

        // Wait for the last responses and let the block settle.
        drain_responses();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.error_count == 0 && sb.pending_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== process_slot_scheduler_core.f =====
sv/psched_pkg.sv
sv/psched_in_if.sv
sv/psched_out_if.sv
sv/psched_alu.sv
sv/psched_table.sv
sv/process_slot_scheduler_core.sv
sim/process_slot_scheduler_core_tb.sv
